@@ rtl/core/sample_select_threshold_filter_core_defines.svh @@
// Assertion macros shared by the checker of the threshold filter core.
// No dependencies; include by bare file name.
`ifndef SAMPLE_SELECT_THRESHOLD_FILTER_CORE_DEFINES_SVH
`define SAMPLE_SELECT_THRESHOLD_FILTER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sstf_pkg.sv @@
// Package of the sample-select threshold filter: sizes, types and the
// magnitude helper. No dependencies.
package sstf_pkg;

    localparam int MAX_ENTRIES  = 4096;
    localparam int TREE_HEIGHT  = 8;
    localparam int OVERSAMPLING = 4;
    localparam int BUCKETS      = 1 << TREE_HEIGHT;
    localparam int SAMPLES      = BUCKETS * OVERSAMPLING;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int SMP_W  = $clog2(SAMPLES);
    localparam int OVS_W  = $clog2(OVERSAMPLING);
    localparam int BKT_W  = TREE_HEIGHT;
    localparam int MAG_W  = 31;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 16;
    localparam int RANK_W = 12;
    localparam int ACC_W  = CNT_W + SMP_W;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FILTER = 1'b1;
    localparam logic KIND_THR  = 1'b0;
    localparam logic KIND_FILT = 1'b1;

    // magnitude store write from the load path
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [MAG_W-1:0]  data;
    } t_ld_wr;

    // start of a threshold computation
    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  count;
        logic [RANK_W-1:0] rank;
    } t_eng_req;

    // finished threshold, held until acknowledged
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] thr;
    } t_eng_rsp;

    // absolute value of signed Q16.16, most negative saturates
    function automatic logic [MAG_W-1:0] mag_of(input logic [VAL_W-1:0] raw);
        logic [VAL_W-1:0] neg;
        neg = ~raw + {{(VAL_W-1){1'b0}}, 1'b1};
        if (raw == {1'b1, {(VAL_W-1){1'b0}}}) begin
            return {MAG_W{1'b1}};
        end else if (raw[VAL_W-1]) begin
            return neg[MAG_W-1:0];
        end
        return raw[MAG_W-1:0];
    endfunction

endpackage

@@ rtl/core/sstf_engine.sv @@
// Threshold engine: magnitude, sample, splitter and histogram memories and the
// sequencer that sorts samples by rank counting, builds the histogram and then
// scans it for the threshold. Depends on sstf_pkg.
module sstf_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sstf_pkg::t_ld_wr   i_ld,
    input  sstf_pkg::t_eng_req i_req,
    input  logic              i_ack,
    output sstf_pkg::t_eng_rsp o_rsp
);
    import sstf_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_SGEN  = 17'h00002,
        S_RSET  = 17'h00004,
        S_RGET  = 17'h00008,
        S_RCNT  = 17'h00010,
        S_RWR   = 17'h00020,
        S_CLR   = 17'h00040,
        S_HRD   = 17'h00080,
        S_HWAIT = 17'h00100,
        S_HSA   = 17'h00200,
        S_HSC   = 17'h00400,
        S_HHA   = 17'h00800,
        S_HHW   = 17'h01000,
        S_SCAN  = 17'h02000,
        S_THR   = 17'h04000,
        S_THR2  = 17'h08000,
        S_DONE  = 17'h10000
    } t_state;

    t_state r_state, n_state;

    // memories
    logic [MAG_W-1:0] mag_mem [MAX_ENTRIES];
    logic [MAG_W-1:0] smp_mem [SAMPLES];
    logic [MAG_W-1:0] spl_mem [BUCKETS];
    logic [CNT_W-1:0] hst_mem [BUCKETS];

    logic [MAG_W-1:0] r_mag_rd, r_smp_rd, r_spl_rd;
    logic [CNT_W-1:0] r_hst_rd;

    logic [ADDR_W-1:0] mag_ra;
    logic [SMP_W-1:0]  smp_ra, smp_wa;
    logic [BKT_W-1:0]  spl_ra, spl_wa, hst_ra, hst_wa;
    logic              smp_we, spl_we, hst_we;
    logic [CNT_W-1:0]  hst_wd;

    // sequencer registers
    logic [CNT_W-1:0]  r_n;
    logic [RANK_W-1:0] r_rank;
    logic [SMP_W:0]    r_i;
    logic [ACC_W-1:0]  r_acc;
    logic [SMP_W-1:0]  r_j;
    logic [SMP_W:0]    r_m;
    logic [MAG_W-1:0]  r_sj;
    logic [SMP_W-1:0]  r_cnt;
    logic [BKT_W:0]    r_b;
    logic [CNT_W-1:0]  r_k;
    logic [MAG_W-1:0]  r_key;
    logic [BKT_W-1:0]  r_lo, r_hi, r_mid, r_bk;
    logic [CNT_W-1:0]  r_cum;
    logic [MAG_W-1:0]  r_thr;

    logic [BKT_W:0]    mid_sum;
    logic [SMP_W-1:0]  m_prev;
    logic              less;
    logic [CNT_W-1:0]  cum_next;

    function automatic logic [BKT_W-1:0] m_bucket(input logic [BKT_W:0] b);
        logic [BKT_W:0] p;
        p = b - {{BKT_W{1'b0}}, 1'b1};
        return p[BKT_W-1:0];
    endfunction

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign m_prev   = r_m[SMP_W-1:0] - {{(SMP_W-1){1'b0}}, 1'b1};
    assign less     = (r_smp_rd < r_sj) || ((r_smp_rd == r_sj) && (m_prev < r_j));
    assign cum_next = r_cum + r_hst_rd;

    // address and write control
    always_comb begin
        mag_ra = r_acc[SMP_W +: ADDR_W];
        smp_ra = r_m[SMP_W-1:0];
        smp_we = 1'b0;
        smp_wa = r_i[SMP_W-1:0] - {{(SMP_W-1){1'b0}}, 1'b1};
        spl_ra = r_mid;
        spl_we = 1'b0;
        spl_wa = r_cnt[SMP_W-1:OVS_W] - {{(BKT_W-1){1'b0}}, 1'b1};
        hst_ra = r_lo;
        hst_we = 1'b0;
        hst_wa = r_lo;
        hst_wd = r_hst_rd + {{(CNT_W-1){1'b0}}, 1'b1};
        unique case (r_state)
            S_SGEN: smp_we = (r_i != '0);
            S_RSET: smp_ra = r_j;
            S_RWR:  spl_we = (r_cnt[OVS_W-1:0] == '0) && (r_cnt[SMP_W-1:OVS_W] != '0);
            S_CLR: begin
                hst_we = 1'b1;
                hst_wa = r_b[BKT_W-1:0];
                hst_wd = '0;
            end
            S_HRD:  mag_ra = r_k[ADDR_W-1:0];
            // fetch the splitter of the midpoint being registered
            S_HSA:  spl_ra = mid_sum[BKT_W:1];
            S_HHW:  hst_we = 1'b1;
            S_SCAN: hst_ra = r_b[BKT_W-1:0];
            S_THR:  spl_ra = r_bk - {{(BKT_W-1){1'b0}}, 1'b1};
            default: ;
        endcase
    end

    // magnitude memory: load writes, sequencer reads
    always_ff @(posedge i_clk) begin
        if (i_ld.we) begin
            mag_mem[i_ld.addr] <= i_ld.data;
        end
        r_mag_rd <= mag_mem[mag_ra];
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            smp_mem[smp_wa] <= r_mag_rd;
        end
        r_smp_rd <= smp_mem[smp_ra];
    end

    // splitter memory
    always_ff @(posedge i_clk) begin
        if (spl_we) begin
            spl_mem[spl_wa] <= r_sj;
        end
        r_spl_rd <= spl_mem[spl_ra];
    end

    // histogram memory; a read of the entry being written returns its old value
    always_ff @(posedge i_clk) begin
        if (hst_we) begin
            hst_mem[hst_wa] <= hst_wd;
        end
        r_hst_rd <= hst_mem[hst_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.start) n_state = S_SGEN;
            S_SGEN:  if (r_i == SMP_W'(0) + (SMP_W+1)'(SAMPLES)) n_state = S_RSET;
            S_RSET:  n_state = S_RGET;
            S_RGET:  n_state = S_RCNT;
            S_RCNT:  if (r_m == (SMP_W+1)'(SAMPLES)) n_state = S_RWR;
            S_RWR:   n_state = (r_j == {SMP_W{1'b1}}) ? S_CLR : S_RSET;
            S_CLR:   if (r_b[BKT_W-1:0] == {BKT_W{1'b1}}) n_state = S_HRD;
            S_HRD:   n_state = S_HWAIT;
            S_HWAIT: n_state = S_HSA;
            S_HSA:   n_state = (r_lo == r_hi) ? S_HHA : S_HSC;
            S_HSC:   n_state = S_HSA;
            S_HHA:   n_state = S_HHW;
            S_HHW:   n_state = (r_k + {{(CNT_W-1){1'b0}}, 1'b1} == r_n) ? S_SCAN : S_HRD;
            S_SCAN: begin
                if ((r_b != '0) && (cum_next > {1'b0, r_rank})) n_state = S_THR;
                else if (r_b == (BKT_W+1)'(BUCKETS)) n_state = S_THR;
            end
            S_THR:   n_state = S_THR2;
            S_THR2:  n_state = S_DONE;
            S_DONE:  if (i_ack) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n    <= i_req.count;
                r_rank <= i_req.rank;
                r_i    <= '0;
                r_acc  <= '0;
                r_j    <= '0;
            end
            // strided samples: index floor(i*n/SAMPLES) by running sum
            S_SGEN: begin
                r_i   <= r_i + 1'b1;
                r_acc <= r_acc + ACC_W'(r_n);
            end
            S_RGET: begin
                r_sj  <= r_smp_rd;
                r_m   <= '0;
                r_cnt <= '0;
            end
            // stable rank of sample j among all samples
            S_RCNT: begin
                r_m <= r_m + 1'b1;
                if ((r_m != '0) && less) r_cnt <= r_cnt + 1'b1;
            end
            S_RWR: begin
                r_j <= r_j + 1'b1;
                r_b <= '0;
                r_k <= '0;
            end
            S_CLR:   r_b <= r_b + 1'b1;
            S_HWAIT: begin
                r_key <= r_mag_rd;
                r_lo  <= '0;
                r_hi  <= {BKT_W{1'b1}};
            end
            S_HSA:   r_mid <= mid_sum[BKT_W:1];
            // binary search step over the splitters
            S_HSC: begin
                if (r_spl_rd <= r_key) r_lo <= r_mid + 1'b1;
                else r_hi <= r_mid;
            end
            S_HHW: begin
                r_k   <= r_k + 1'b1;
                r_b   <= '0;
                r_cum <= '0;
            end
            // prefix sum until the rank falls inside a bucket
            S_SCAN: begin
                r_b <= r_b + 1'b1;
                if (r_b != '0) begin
                    r_cum <= cum_next;
                    r_bk  <= m_bucket(r_b);
                end
            end
            S_THR2:  r_thr <= (r_bk == '0) ? '0 : r_spl_rd;
            default: ;
        endcase
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.thr  = r_thr;

endmodule

@@ rtl/core/sample_select_threshold_filter_core.sv @@
// Channel    | dir | handshake             | payload
// s_axis     | in  | tvalid/tready         | tdata value,row,col; tuser op; tlast last load
// m_axis     | out | tvalid/tready         | tdata thr,keep,row,col,value; tuser kind
// cfg        | in  | i_cfg_we              | i_cfg_wdata target rank
// Load and filter items are accepted back to back while the output register is free.
// A last load starts the threshold engine, whose run time is set mostly by the rank
// count over the sample memory. No item is accepted meanwhile.
// Reset (synchronous, active low) clears the count, threshold and valid flags.
// Depends on sstf_pkg and sstf_engine.
module sample_select_threshold_filter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sstf_pkg::RANK_W-1:0] i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,  // value[31:0], row, col
    input  logic                       s_axis_tuser,  // operation
    input  logic                       s_axis_tlast,  // last_load
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [95:0]                m_axis_tdata,  // threshold, keep, row, col, value
    output logic                       m_axis_tuser   // result_kind
);
    import sstf_pkg::*;

    logic [RANK_W-1:0] r_rank;
    logic [CNT_W-1:0]  r_count;
    logic [MAG_W-1:0]  r_thr;
    logic              r_busy;
    logic              r_ovld;
    logic [95:0]       r_odata;
    logic              r_okind;

    t_ld_wr   ld;
    t_eng_req req;
    t_eng_rsp rsp;

    logic             out_free, acc, is_load, stored, ack;
    logic [VAL_W-1:0] in_val;
    logic [IDX_W-1:0] in_row, in_col;
    logic [MAG_W-1:0] in_mag;
    logic [CNT_W-1:0] n_cnt;
    logic             keep;

    assign in_val  = s_axis_tdata[31:0];
    assign in_row  = s_axis_tdata[47:32];
    assign in_col  = s_axis_tdata[63:48];
    assign in_mag  = mag_of(in_val);
    assign out_free = !r_ovld || m_axis_tready;
    assign s_axis_tready = !r_busy && out_free;
    assign acc     = s_axis_tvalid && s_axis_tready;
    assign is_load = (s_axis_tuser == OP_LOAD);
    assign stored  = !r_count[CNT_W-1];
    assign n_cnt   = r_count + CNT_W'(stored);
    assign keep    = (in_mag >= r_thr) || (in_row == in_col);
    assign ack     = rsp.done && out_free;

    // store write and engine start
    assign ld.we    = acc && is_load && stored;
    assign ld.addr  = r_count[ADDR_W-1:0];
    assign ld.data  = in_mag;
    assign req.start = acc && is_load && s_axis_tlast;
    assign req.count = n_cnt;
    assign req.rank  = ({1'b0, r_rank} < n_cnt) ? r_rank
                                                 : RANK_W'(n_cnt - {{(CNT_W-1){1'b0}}, 1'b1});

    sstf_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (ld),
        .i_req   (req),
        .i_ack   (ack),
        .o_rsp   (rsp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank  <= '0;
            r_count <= '0;
            r_thr   <= '0;
            r_busy  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cfg_we) r_rank <= i_cfg_wdata;
            if (req.start) begin
                r_count <= '0;
                r_busy  <= 1'b1;
            end else if (ld.we) begin
                r_count <= n_cnt;
            end
            if (ack) begin
                r_thr  <= rsp.thr;
                r_busy <= 1'b0;
            end
            if (ack || (acc && !is_load)) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
        end
    end

    // output item register
    always_ff @(posedge i_clk) begin
        if (ack) begin
            r_okind <= KIND_THR;
            r_odata <= {64'd0, 1'b0, rsp.thr};
        end else if (acc && !is_load) begin
            r_okind <= KIND_FILT;
            r_odata <= {in_val, in_col, in_row, keep, r_thr};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;

endmodule

@@ rtl/core/sstf_checker.sv @@
// Port-level checker for the threshold filter core and its bind.
// Depends on sample_select_threshold_filter_core_defines.svh.
`include "sample_select_threshold_filter_core_defines.svh"

module sstf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // stalled output item holds
    `SSTF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")
    // threshold item carries zero entry fields
    `SSTF_ASSERT_NOW(a_thr_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[95:31] == 65'd0, "threshold item has nonzero entry fields")
    // diagonal entries are always kept
    `SSTF_ASSERT_NOW(a_diag_keep, m_axis_tvalid && m_axis_tuser && (m_axis_tdata[47:32] == m_axis_tdata[63:48]), m_axis_tdata[31], "diagonal entry dropped")
    // a last load starts the engine and blocks input
    `SSTF_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && !s_axis_tuser && s_axis_tlast, !s_axis_tready, "input accepted right after last load")
endmodule

bind sample_select_threshold_filter_core sstf_checker u_sstf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_sample_select_threshold_filter_core.sv @@
// Testbench of the sample-select threshold filter core: load batches, filter items,
// and a scoreboard that predicts each result. Depends on sstf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_sample_select_threshold_filter_core;
    import sstf_pkg::*;

    localparam int  CLK_PERIOD  = 12;
    localparam int  CYCLE_LIMIT = 20_000_000;
    localparam int  DRAIN_WAIT  = 40;

    typedef struct {
        logic             kind;
        logic [MAG_W-1:0] thr;
        logic             keep;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RANK_W-1:0]   i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;   // value[31:0], row[47:32], col[63:48]
    logic                s_axis_tuser;   // operation
    logic                s_axis_tlast;   // last_load
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [95:0]         m_axis_tdata;   // threshold[30:0], keep[31], row, col, value
    logic                m_axis_tuser;   // result_kind

    // predictor state
    logic [MAG_W-1:0]  mag_mem [MAX_ENTRIES];
    int unsigned       stored_count;
    logic [MAG_W-1:0]  cur_thr;
    logic [RANK_W-1:0] cur_rank;
    t_result           pending_results[$];
    logic [VAL_W-1:0]  loaded_vals[$];

    int unsigned cycle_count;
    int unsigned accepted_items;
    int unsigned checked_results;
    int unsigned thresholds_seen;
    int unsigned error_count;
    int unsigned burst_left;
    int unsigned hold_left;
    int unsigned ready_phase;

    sample_select_threshold_filter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // absolute value, most negative value saturates
    function automatic logic [MAG_W-1:0] abs_q16(input logic [VAL_W-1:0] raw);
        logic [VAL_W-1:0] neg;
        neg = -raw;
        if (raw == 32'h8000_0000) return 31'h7FFF_FFFF;
        if (raw[31]) return neg[30:0];
        return raw[30:0];
    endfunction

    // strided samples, sorted, splitters, histogram, then rank lookup
    function automatic logic [MAG_W-1:0] estimate_threshold();
        logic [MAG_W-1:0] smp[$];
        logic [MAG_W-1:0] split [BUCKETS-1];
        int unsigned      hist [BUCKETS+1];
        longint unsigned  idx;
        int unsigned      n, rank, sum, pos, lo, hi, mid, b;
        n = stored_count;
        if (n == 0) return '0;
        for (int i = 0; i < SAMPLES; i++) begin
            idx = (longint'(i) * n) / SAMPLES;
            smp.push_back(mag_mem[idx]);
        end
        smp.sort();
        for (int i = 0; i < BUCKETS - 1; i++) split[i] = smp[(i + 1) * OVERSAMPLING];
        foreach (hist[i]) hist[i] = 0;
        for (int i = 0; i < n; i++) begin
            lo = 0;
            hi = BUCKETS - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (split[mid] <= mag_mem[i]) lo = mid + 1;
                else hi = mid;
            end
            hist[lo]++;
        end
        rank = (cur_rank < n) ? cur_rank : n - 1;
        // sum tracks the exclusive prefix at pos
        pos = 0;
        sum = 0;
        while (pos <= BUCKETS && sum <= rank) begin
            sum += hist[pos];
            pos++;
        end
        if (pos < 1) pos = 1;
        b = pos - 1;
        return (b > 0) ? split[b-1] : '0;
    endfunction

    // input monitor and predictor
    always @(posedge i_clk) begin
        t_result          r;
        logic [VAL_W-1:0] raw;
        logic [MAG_W-1:0] m;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            accepted_items <= accepted_items + 1;
            raw = s_axis_tdata[31:0];
            m   = abs_q16(raw);
            r   = '{kind: KIND_FILT, thr: '0, keep: 1'b0, row: '0, col: '0, value: '0};
            if (s_axis_tuser == OP_LOAD) begin
                if (stored_count < MAX_ENTRIES) begin
                    mag_mem[stored_count] = m;
                    stored_count++;
                end
                if (s_axis_tlast) begin
                    cur_thr = estimate_threshold();
                    stored_count = 0;
                    r.kind = KIND_THR;
                    r.thr  = cur_thr;
                    pending_results.push_back(r);
                end
            end else begin
                r.thr   = cur_thr;
                r.row   = s_axis_tdata[47:32];
                r.col   = s_axis_tdata[63:48];
                r.value = raw;
                r.keep  = (m >= cur_thr) || (r.row == r.col);
                pending_results.push_back(r);
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [95:0] got,
                                   input logic [95:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                w = pending_results.pop_front();
                checked_results++;
                if (w.kind == KIND_THR) thresholds_seen++;
                if (m_axis_tuser !== w.kind) report_mismatch("kind", m_axis_tuser, w.kind);
                if (m_axis_tdata[30:0] !== w.thr)
                    report_mismatch("threshold", m_axis_tdata[30:0], w.thr);
                if (m_axis_tdata[31] !== w.keep) report_mismatch("keep", m_axis_tdata[31], w.keep);
                if (m_axis_tdata[47:32] !== w.row)
                    report_mismatch("row", m_axis_tdata[47:32], w.row);
                if (m_axis_tdata[63:48] !== w.col)
                    report_mismatch("col", m_axis_tdata[63:48], w.col);
                if (m_axis_tdata[95:64] !== w.value)
                    report_mismatch("value", m_axis_tdata[95:64], w.value);
            end
        end
    end

    // receiver: long hold when asked, else alternating quiet and random stall stretches
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            ready_phase++;
            if ((ready_phase / 400) % 2 == 0) m_axis_tready = 1'b1;
            else m_axis_tready = ($urandom_range(0, 3) != 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[sample_select_threshold_filter_core] ERROR");
            $finish;
        end
    end

    // sends one item, with bursts and random gaps; returns at the negedge after acceptance
    task automatic send_item(input logic op, input logic [VAL_W-1:0] value,
                             input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic last);
        int unsigned start;
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, $urandom};
            s_axis_tuser  = $urandom_range(0, 1);
            s_axis_tlast  = $urandom_range(0, 1);
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {col, row, value};
        s_axis_tuser  = op;
        s_axis_tlast  = last;
        start = accepted_items;
        do @(negedge i_clk); while (accepted_items == start);
        burst_left--;
    endtask

    task automatic idle_input();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
    endtask

    // wait until every expected result has come, plus engine settling
    task automatic drain();
        idle_input();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] rank);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = rank;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = $urandom;
        cur_rank    = rank;
    endtask

    task automatic load_value(input logic [VAL_W-1:0] v, input logic last);
        loaded_vals.push_back(v);
        send_item(OP_LOAD, v, $urandom, $urandom, last);
    endtask

    // value close to something loaded, or anything at all
    function automatic logic [VAL_W-1:0] near_loaded();
        logic [VAL_W-1:0] v;
        if (loaded_vals.size() == 0 || $urandom_range(0, 3) == 0) return $urandom;
        v = loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
        return v + $urandom_range(0, 4) - 2;
    endfunction

    task automatic filter_random(input int unsigned count);
        logic [IDX_W-1:0] r;
        for (int i = 0; i < count; i++) begin
            r = $urandom;
            send_item(OP_FILTER, near_loaded(), r,
                      ($urandom_range(0, 5) == 0) ? r : IDX_W'($urandom),
                      $urandom_range(0, 1));
        end
    endtask

    // directed: reset threshold, field extremes, saturation, diagonal, ignored last
    task automatic test_extremes();
        send_item(OP_FILTER, 32'h0000_0000, 16'h0000, 16'hFFFF, 1'b0);
        send_item(OP_FILTER, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 1'b1);
        drain();
        write_rank(12'd0);
        load_value(32'h8000_0000, 1'b0);
        load_value(32'h7FFF_FFFF, 1'b0);
        load_value(32'hFFFF_FFFF, 1'b0);
        load_value(32'h0000_0000, 1'b0);
        load_value(32'h0001_0000, 1'b0);
        load_value(32'hFFFF_0000, 1'b0);
        load_value(32'h0000_8000, 1'b1);
        send_item(OP_FILTER, 32'h0000_0000, 16'h0001, 16'h0002, 1'b0);
        send_item(OP_FILTER, 32'h0000_0000, 16'h1234, 16'h1234, 1'b0);
        send_item(OP_FILTER, 32'h8000_0000, 16'hFFFF, 16'h0000, 1'b1);
        send_item(OP_FILTER, 32'h7FFF_FFFF, 16'h0000, 16'h0001, 1'b0);
        send_item(OP_FILTER, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555, 1'b0);
        drain();
    endtask

    // rank beyond the batch size saturates to the largest magnitude's bucket
    task automatic test_rank_saturation();
        write_rank(12'd4095);
        for (int i = 0; i < 20; i++) load_value($urandom_range(0, 32'h0010_0000), i == 19);
        filter_random(20);
        drain();
    endtask

    // receiver holds off long while items keep coming
    task automatic test_backpressure();
        hold_left = 300;
        filter_random(60);
        drain();
    endtask

    // random batch with random rank, mostly well-formed
    task automatic test_random_batch();
        int unsigned n;
        write_rank($urandom_range(0, 400));
        loaded_vals.delete();
        n = $urandom_range(150, 250);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) load_value($urandom, i == n - 1);
            else load_value($urandom_range(0, 32'h0004_0000) - 32'h0002_0000, i == n - 1);
        end
        filter_random(120);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        stored_count  = 0;
        cur_thr       = '0;
        cur_rank      = '0;
        cycle_count   = 0;
        accepted_items = 0;
        checked_results = 0;
        thresholds_seen = 0;
        error_count   = 0;
        burst_left    = 0;
        hold_left     = 0;
        ready_phase   = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_rank_saturation();
        test_backpressure();
        test_random_batch();
        drain();

        $display("covered %0d items, %0d results checked, %0d threshold estimates",
                 accepted_items, checked_results, thresholds_seen);
        $display("ranks 0, 4095 and random; saturated magnitudes; long output hold");
        if (error_count == 0) begin
            $display("[sample_select_threshold_filter_core] OK");
        end else begin
            $display("[sample_select_threshold_filter_core] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sstf_pkg.sv
rtl/core/sstf_engine.sv
rtl/core/sample_select_threshold_filter_core.sv
rtl/core/sstf_checker.sv
tb/tb_sample_select_threshold_filter_core.sv
